/* hdl/assert_macros.svh */
// assertion helpers used by the checker file jts_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is applied
`define JTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is applied
`define JTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/jts_pkg.sv */
// ----------------------------------------------------------------------------
// jts_pkg
// Token and error codes, result record and keyword tables of the JSON scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

	localparam int KIND_W = 4;
	localparam int ERR_W  = 3;
	localparam int LINE_W = 24;
	localparam int LEN_W  = 7;

	localparam logic [KIND_W-1:0] TK_LBRACKET = 4'd0;
	localparam logic [KIND_W-1:0] TK_RBRACKET = 4'd1;
	localparam logic [KIND_W-1:0] TK_LBRACE   = 4'd2;
	localparam logic [KIND_W-1:0] TK_RBRACE   = 4'd3;
	localparam logic [KIND_W-1:0] TK_COMMA    = 4'd4;
	localparam logic [KIND_W-1:0] TK_COLON    = 4'd5;
	localparam logic [KIND_W-1:0] TK_STRING   = 4'd6;
	localparam logic [KIND_W-1:0] TK_NUMBER   = 4'd7;
	localparam logic [KIND_W-1:0] TK_TRUE     = 4'd8;
	localparam logic [KIND_W-1:0] TK_FALSE    = 4'd9;
	localparam logic [KIND_W-1:0] TK_NULL     = 4'd10;
	localparam logic [KIND_W-1:0] TK_EOF      = 4'd11;
	localparam logic [KIND_W-1:0] TK_ERROR    = 4'd12;

	localparam logic [ERR_W-1:0] EC_NONE       = 3'd0;
	localparam logic [ERR_W-1:0] EC_UNTERM     = 3'd1;
	localparam logic [ERR_W-1:0] EC_POINT      = 3'd2;
	localparam logic [ERR_W-1:0] EC_EXP        = 3'd3;
	localparam logic [ERR_W-1:0] EC_SIGN       = 3'd4;
	localparam logic [ERR_W-1:0] EC_EOF_NUM    = 3'd5;
	localparam logic [ERR_W-1:0] EC_UNEXPECTED = 3'd6;

	// keyword selectors
	localparam logic [1:0] KW_NULL  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_TRUE  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ERR_W-1:0]  err;
		logic [LINE_W-1:0] line;
		logic [LEN_W-1:0]  len;
		logic              last;
	} jts_result_t;

	localparam logic [7:0] KW_TEXT [3][5] = '{
		'{"n", "u", "l", "l", 8'h00},
		'{"f", "a", "l", "s", "e"},
		'{"t", "r", "u", "e", 8'h00}
	};

	function automatic jts_result_t mk_res(input logic [KIND_W-1:0] kind,
			input logic [ERR_W-1:0] err, input logic [LINE_W-1:0] line,
			input logic [LEN_W-1:0] len);
		jts_result_t r;
		r.kind = kind;
		r.err  = err;
		r.line = line;
		r.len  = len;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] sel);
		return (sel == KW_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [KIND_W-1:0] kw_kind(input logic [1:0] sel);
		logic [KIND_W-1:0] k;
		unique case (sel)
			KW_FALSE: k = TK_FALSE;
			KW_TRUE:  k = TK_TRUE;
			default:  k = TK_NULL;
		endcase
		return k;
	endfunction

	// expected letter, zero past the end; upper case is the lower letter minus 0x20
	function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos,
			input logic upper);
		logic [7:0] c;
		c = 8'h00;
		if (pos < kw_len(sel)) begin
			c = KW_TEXT[sel][pos];
			if (upper)
				c = c - 8'h20;
		end
		return c;
	endfunction

endpackage

/* hdl/jts_if.sv */
// ----------------------------------------------------------------------------
// jts_byte_if / jts_token_if
// Valid/ready channels for source bytes and for scanned tokens.
// ----------------------------------------------------------------------------
interface jts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_input;

	modport source (output valid, output byte_in, output end_of_input, input ready);
	modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface jts_token_if import jts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] token_kind;
	logic [ERR_W-1:0]  error_code;
	logic [LINE_W-1:0] line_number;
	logic [LEN_W-1:0]  lexeme_length;
	logic              last_result;

	modport source (output valid, output token_kind, output error_code, output line_number,
		output lexeme_length, output last_result, input ready);
	modport sink (input valid, input token_kind, input error_code, input line_number,
		input lexeme_length, input last_result, output ready);
endinterface

/* hdl/json_token_scanner.sv */
// ----------------------------------------------------------------------------
// json_token_scanner
// Byte-serial JSON lexer with line tracking and error recovery to the newline.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle and returns its tokens in order. A byte is
// registered, scanned when there is room for its results, and its zero to two
// results are written into a four-entry result queue that drives the token
// port, so a new byte can be taken in every cycle while results wait to be
// collected. The sustained rate is one byte per clock; it falls only when
// results come out faster than one per cycle on average, or the token sink
// stalls, as the token port hands out one result per transfer. A byte passes
// the input register and the result queue before its first result is offered.
module json_token_scanner import jts_pkg::*; #(
	parameter int LEXEME_LIMIT = 64,
	parameter int LINE_BITS    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	jts_byte_if.sink    bytes,
	jts_token_if.source tokens
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;
	logic        advance;
	logic        room;
	jts_result_t res0, res1, head;
	logic [1:0]  res_cnt;

	assign advance     = valid_s1 && room;
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (bytes.ready)
			valid_s1 <= bytes.valid;
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.byte_in;
			eof_s1  <= bytes.end_of_input;
		end
	end

	jts_scan #(
		.LEXEME_LIMIT(LEXEME_LIMIT),
		.LINE_BITS(LINE_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.byte_in(byte_s1),
		.end_of_input(eof_s1),
		.res0(res0),
		.res1(res1),
		.res_cnt(res_cnt)
	);

	jts_rbuf u_rbuf (
		.clk(clk),
		.arst_n(arst_n),
		.push_cnt(advance ? res_cnt : 2'd0),
		.push0(res0),
		.push1(res1),
		.room(room),
		.out_valid(tokens.valid),
		.out_ready(tokens.ready),
		.out_data(head)
	);

	assign tokens.token_kind    = head.kind;
	assign tokens.error_code    = head.err;
	assign tokens.line_number   = head.line;
	assign tokens.lexeme_length = head.len;
	assign tokens.last_result   = head.last;

endmodule

/* hdl/jts_scan.sv */
// ----------------------------------------------------------------------------
// jts_scan
// Scanner state and next-state logic: one byte in, zero to two results out.
// ----------------------------------------------------------------------------
module jts_scan import jts_pkg::*; #(
	parameter int LEXEME_LIMIT = 64,
	parameter int LINE_BITS    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  logic        end_of_input,
	output jts_result_t res0,
	output jts_result_t res1,
	output logic [1:0]  res_cnt
);

	localparam int TL_W = $clog2(LEXEME_LIMIT + 1);
	localparam logic [TL_W-1:0] LIM = TL_W'(LEXEME_LIMIT);
	localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

	// number phases, plus two outcome codes
	localparam logic [2:0] PH_INT   = 3'd0;
	localparam logic [2:0] PH_POINT = 3'd1;
	localparam logic [2:0] PH_FRAC  = 3'd2;
	localparam logic [2:0] PH_EXP   = 3'd3;
	localparam logic [2:0] PH_ESIGN = 3'd4;
	localparam logic [2:0] PH_EDIG  = 3'd5;
	localparam logic [2:0] NX_ERR   = 3'd6;
	localparam logic [2:0] NX_DONE  = 3'd7;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_STR  = 3'd1,
		M_NUM  = 3'd2,
		M_KEY  = 3'd3,
		M_SKIP = 3'd4
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [2:0]           phase_q, phase_d;
	logic [1:0]           ksel_q, ksel_d;
	logic [2:0]           kpos_q, kpos_d;
	logic                 kup_q, kup_d;
	logic [TL_W-1:0]      tlen_q, tlen_d;
	logic [LINE_BITS-1:0] line_q, line_d;

	logic [TL_W-1:0]           tlen_g;
	logic [TL_W+LEN_W-1:0]     t_ext, g_ext;
	logic [LEN_W-1:0]          t_len, g_len;
	logic [LINE_BITS+LINE_W-1:0] line_ext;
	logic [LINE_W-1:0]         line_out;

	logic is_digit, is_sign, is_e;
	logic [1:0] sel3;
	logic [2:0] kpos_inc;
	logic [7:0] want;
	logic [2:0] nx;
	logic [ERR_W-1:0] ncode;

	// idle-mode decode, shared by idle mode and the byte that closes a number
	logic              i_emit, i_nl, i_tlen_we, i_tlen_one, i_key;
	logic [KIND_W-1:0] i_kind;
	logic [ERR_W-1:0]  i_err;
	logic [LEN_W-1:0]  i_len;
	mode_t             i_mode;
	logic [1:0]        i_ksel;

	jts_result_t res [2];
	logic [1:0]  n;
	logic        nl;
	logic        use_idle;

	assign tlen_g   = (tlen_q < LIM) ? tlen_q + 1'b1 : tlen_q;
	assign t_ext    = {{LEN_W{1'b0}}, tlen_q};
	assign g_ext    = {{LEN_W{1'b0}}, tlen_g};
	assign t_len    = t_ext[LEN_W-1:0];
	assign g_len    = g_ext[LEN_W-1:0];
	assign line_ext = {{LINE_W{1'b0}}, line_q};
	assign line_out = line_ext[LINE_W-1:0];

	assign is_digit = (byte_in >= "0") && (byte_in <= "9");
	assign is_sign  = (byte_in == "+") || (byte_in == "-");
	assign is_e     = (byte_in == "e") || (byte_in == "E");
	assign sel3     = (ksel_q == 2'd3) ? KW_NULL : ksel_q;
	assign want     = kw_char(sel3, kpos_q, kup_q);
	assign kpos_inc = kpos_q + 1'b1;

	always_comb begin
		i_emit     = 1'b0;
		i_nl       = 1'b0;
		i_tlen_we  = 1'b0;
		i_tlen_one = 1'b0;
		i_key      = 1'b0;
		i_kind     = TK_ERROR;
		i_err      = EC_NONE;
		i_len      = LEN_W'(1);
		i_mode     = M_IDLE;
		i_ksel     = KW_NULL;
		if (byte_in == "n" || byte_in == "N")
			i_ksel = KW_NULL;
		else if (byte_in == "f" || byte_in == "F")
			i_ksel = KW_FALSE;
		else
			i_ksel = KW_TRUE;
		priority if (byte_in == "\n") begin
			i_nl = 1'b1;
		end else if (byte_in == " " || byte_in == "\t") begin
			i_emit = 1'b0;
		end else if (byte_in == "[") begin
			i_emit = 1'b1;
			i_kind = TK_LBRACKET;
		end else if (byte_in == "]") begin
			i_emit = 1'b1;
			i_kind = TK_RBRACKET;
		end else if (byte_in == "{") begin
			i_emit = 1'b1;
			i_kind = TK_LBRACE;
		end else if (byte_in == "}") begin
			i_emit = 1'b1;
			i_kind = TK_RBRACE;
		end else if (byte_in == ",") begin
			i_emit = 1'b1;
			i_kind = TK_COMMA;
		end else if (byte_in == ":") begin
			i_emit = 1'b1;
			i_kind = TK_COLON;
		end else if (byte_in == "\"") begin
			i_tlen_we  = 1'b1;
			i_tlen_one = 1'b1;
			i_mode     = M_STR;
		end else if (is_digit || is_sign) begin
			i_tlen_we  = 1'b1;
			i_tlen_one = 1'b1;
			i_mode     = M_NUM;
		end else if (byte_in == "n" || byte_in == "N" || byte_in == "f" || byte_in == "F" ||
				byte_in == "t" || byte_in == "T") begin
			i_tlen_we  = 1'b1;
			i_tlen_one = 1'b1;
			i_key      = 1'b1;
			i_mode     = M_KEY;
		end else begin
			i_tlen_we = 1'b1;
			i_emit    = 1'b1;
			i_kind    = TK_ERROR;
			i_err     = EC_UNEXPECTED;
			i_len     = '0;
			i_mode    = M_SKIP;
		end
	end

	// number phase transitions
	always_comb begin
		nx    = NX_DONE;
		ncode = EC_NONE;
		unique case (phase_q)
			PH_INT:   nx = is_digit ? PH_INT : (byte_in == ".") ? PH_POINT :
				is_e ? PH_EXP : NX_DONE;
			PH_POINT: begin
				nx    = is_digit ? PH_FRAC : NX_ERR;
				ncode = EC_POINT;
			end
			PH_FRAC:  nx = is_digit ? PH_FRAC : is_e ? PH_EXP : NX_DONE;
			PH_EXP: begin
				nx    = is_sign ? PH_ESIGN : is_digit ? PH_EDIG : NX_ERR;
				ncode = EC_EXP;
			end
			PH_ESIGN: begin
				nx    = is_digit ? PH_EDIG : NX_ERR;
				ncode = EC_SIGN;
			end
			default:  nx = is_digit ? PH_EDIG : NX_DONE;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		phase_d  = phase_q;
		ksel_d   = ksel_q;
		kpos_d   = kpos_q;
		kup_d    = kup_q;
		tlen_d   = tlen_q;
		res[0]   = '0;
		res[1]   = '0;
		n        = 2'd0;
		nl       = 1'b0;
		use_idle = 1'b0;
		if (end_of_input) begin
			unique case (mode_q)
				M_STR: begin
					res[0] = mk_res(TK_STRING, EC_UNTERM, line_out, t_len);
					n      = 2'd1;
				end
				M_NUM: begin
					if (phase_q == PH_POINT || phase_q == PH_EXP || phase_q == PH_ESIGN)
						res[0] = mk_res(TK_ERROR, EC_EOF_NUM, line_out, '0);
					else
						res[0] = mk_res(TK_NUMBER, EC_NONE, line_out, t_len);
					n = 2'd1;
				end
				M_KEY: begin
					res[0] = mk_res(TK_ERROR, EC_UNEXPECTED, line_out, '0);
					n      = 2'd1;
				end
				default: n = 2'd0;
			endcase
			res[n[0]] = mk_res(TK_EOF, EC_NONE, line_out, '0);
			n         = n + 2'd1;
			mode_d    = M_IDLE;
			phase_d   = PH_INT;
			kpos_d    = '0;
			tlen_d    = '0;
		end else begin
			unique case (mode_q)
				M_STR: begin
					if (byte_in == "\"") begin
						tlen_d = tlen_g;
						res[0] = mk_res(TK_STRING, EC_NONE, line_out, g_len);
						n      = 2'd1;
						mode_d = M_IDLE;
					end else if (byte_in == "," || byte_in == ":" || byte_in == "\n") begin
						res[0] = mk_res(TK_STRING, EC_UNTERM, line_out, t_len);
						n      = 2'd1;
						nl     = (byte_in == "\n");
						mode_d = M_IDLE;
					end else begin
						tlen_d = tlen_g;
					end
				end
				M_NUM: begin
					if (nx == NX_ERR) begin
						res[0]  = mk_res(TK_ERROR, ncode, line_out, '0);
						n       = 2'd1;
						phase_d = PH_INT;
						nl      = (byte_in == "\n");
						mode_d  = (byte_in == "\n") ? M_IDLE : M_SKIP;
					end else if (nx == NX_DONE) begin
						// the closing byte is scanned again as a fresh token start
						res[0]   = mk_res(TK_NUMBER, EC_NONE, line_out, t_len);
						n        = 2'd1;
						phase_d  = PH_INT;
						use_idle = 1'b1;
					end else begin
						tlen_d  = tlen_g;
						phase_d = nx;
					end
				end
				M_KEY: begin
					if (want != 8'h00 && byte_in == want) begin
						tlen_d = tlen_g;
						if (kpos_inc >= kw_len(sel3)) begin
							res[0] = mk_res(kw_kind(sel3), EC_NONE, line_out, g_len);
							n      = 2'd1;
							kpos_d = '0;
							mode_d = M_IDLE;
						end else begin
							kpos_d = kpos_inc;
						end
					end else begin
						res[0] = mk_res(TK_ERROR, EC_UNEXPECTED, line_out, '0);
						n      = 2'd1;
						kpos_d = '0;
						nl     = (byte_in == "\n");
						mode_d = (byte_in == "\n") ? M_IDLE : M_SKIP;
					end
				end
				M_SKIP: begin
					if (byte_in == "\n") begin
						nl     = 1'b1;
						mode_d = M_IDLE;
					end
				end
				default: use_idle = 1'b1;
			endcase
			if (use_idle) begin
				mode_d = i_mode;
				nl     = i_nl;
				if (i_tlen_we)
					tlen_d = i_tlen_one ? TL_W'(1) : '0;
				if (i_mode == M_NUM)
					phase_d = PH_INT;
				if (i_key) begin
					ksel_d = i_ksel;
					kup_d  = (byte_in < "a");
					kpos_d = 3'd1;
				end
				if (i_emit) begin
					res[n[0]] = mk_res(i_kind, i_err, line_out, i_len);
					n         = n + 2'd1;
				end
			end
		end
		if (n != 2'd0)
			res[~n[0]].last = 1'b1;
	end

	assign line_d  = (nl && line_q != LINE_TOP) ? line_q + 1'b1 : line_q;
	assign res0    = res[0];
	assign res1    = res[1];
	assign res_cnt = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			phase_q <= PH_INT;
			ksel_q  <= KW_NULL;
			kpos_q  <= '0;
			kup_q   <= 1'b0;
			tlen_q  <= '0;
			line_q  <= LINE_BITS'(1);
		end else if (step) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			ksel_q  <= ksel_d;
			kpos_q  <= kpos_d;
			kup_q   <= kup_d;
			tlen_q  <= tlen_d;
			line_q  <= line_d;
		end
	end

endmodule

/* hdl/jts_rbuf.sv */
// ----------------------------------------------------------------------------
// jts_rbuf
// Four-entry result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module jts_rbuf import jts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  push_cnt,
	input  jts_result_t push0,
	input  jts_result_t push1,
	output logic        room,
	output logic        out_valid,
	input  logic        out_ready,
	output jts_result_t out_data
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	jts_result_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rp_q];
	// room for a worst-case byte, whatever leaves this cycle
	assign room      = (cnt_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wp_q] <= push0;
		if (push_cnt == 2'd2)
			mem_q[wp_q + 1'b1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(push_cnt);
			rp_q  <= rp_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

endmodule

/* hdl/jts_checker.sv */
// ----------------------------------------------------------------------------
// jts_checker
// Port-level checks on the token channel of the scanner.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jts_checker import jts_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [KIND_W-1:0] token_kind,
	input logic [ERR_W-1:0]  error_code,
	input logic [LINE_W-1:0] line_number,
	input logic [LEN_W-1:0]  lexeme_length,
	input logic              last_result
);

	`JTS_ASSERT_NEXT(a_hold, clk, arst_n, (out_valid && !out_ready), (out_valid && $stable({token_kind, error_code, line_number, lexeme_length, last_result})), "token changed while stalled")
	`JTS_ASSERT_IMPLY(a_kind, clk, arst_n, out_valid, (token_kind <= TK_ERROR), "token kind out of range")
	`JTS_ASSERT_IMPLY(a_code, clk, arst_n, out_valid, (error_code == EC_NONE || token_kind == TK_ERROR || token_kind == TK_STRING), "error code on a clean token")
	`JTS_ASSERT_IMPLY(a_eof, clk, arst_n, (out_valid && token_kind == TK_EOF), (last_result && lexeme_length == '0 && error_code == EC_NONE), "eof token not last or not empty")
	`JTS_ASSERT_IMPLY(a_err, clk, arst_n, (out_valid && token_kind == TK_ERROR), (error_code != EC_NONE && error_code != EC_UNTERM && lexeme_length == '0), "malformed error token")

endmodule

bind json_token_scanner jts_checker u_jts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(tokens.valid),
	.out_ready(tokens.ready),
	.token_kind(tokens.token_kind),
	.error_code(tokens.error_code),
	.line_number(tokens.line_number),
	.lexeme_length(tokens.lexeme_length),
	.last_result(tokens.last_result)
);

/* sim/json_token_scanner_tb.sv */
// ----------------------------------------------------------------------------
// json_token_scanner_tb
// Self-checking bench: byte stream in, predicted token stream compared out.
// ----------------------------------------------------------------------------
// A queue of pending bytes feeds a clocked driver; a clocked monitor checks
// every token against the next one predicted by a local copy of the lexer.
// Stimulus is a directed JSON fragment followed by random fragments of JSON
// (punctuation, strings, numbers, keywords, broken variants and noise), run
// under several source-idle and sink-stall mixes, with one long sink hold.
module json_token_scanner_tb;
	import jts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         LEXEME_MAX  = 64;
	localparam int         HOLD_CYCLES = 150;
	localparam int         STALL_LIMIT = 2000;
	localparam int         TAIL_CYCLES = 8;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_TAB      = 8'h09;

	// number sub-states, plus the two outcomes of a step
	localparam logic [2:0] NP_INT      = 3'd0;
	localparam logic [2:0] NP_POINT    = 3'd1;
	localparam logic [2:0] NP_FRAC     = 3'd2;
	localparam logic [2:0] NP_EXP      = 3'd3;
	localparam logic [2:0] NP_EXPSIGN  = 3'd4;
	localparam logic [2:0] NP_EXPDIG   = 3'd5;
	localparam logic [2:0] NP_BAD      = 3'd6;
	localparam logic [2:0] NP_DONE     = 3'd7;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_STRING,
		SCAN_NUMBER,
		SCAN_WORD,
		SCAN_SKIP
	} scan_mode_e;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
	} src_byte_t;

	logic clk;
	logic arst_n;

	jts_byte_if  bytes_ch ();
	jts_token_if tokens_ch ();

	json_token_scanner u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.tokens (tokens_ch)
	);

	src_byte_t   byte_backlog [$];
	jts_result_t tokens_due [$];

	int src_idle_pct;
	int sink_stall_pct;
	int mismatches;
	int quiet_cycles;
	int hold_left;
	bit hold_req;
	bit hold_seen;

	// lexer state as the predictor sees it
	scan_mode_e        mode;
	logic [2:0]        num_ph;
	logic [1:0]        kw_which;
	logic [2:0]        kw_at;
	logic              kw_caps;
	logic [LEN_W-1:0]  text_len;
	logic [LINE_W-1:0] cur_line;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [2:0] word_size(input logic [1:0] sel);
		return (sel == KW_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [KIND_W-1:0] word_kind(input logic [1:0] sel);
		case (sel)
			KW_NULL:  return TK_NULL;
			KW_FALSE: return TK_FALSE;
			default:  return TK_TRUE;
		endcase
	endfunction

	// zero past the end of the word
	function automatic logic [7:0] word_letter(input logic [1:0] sel, input logic [2:0] pos,
			input logic caps);
		string      w;
		logic [7:0] c;
		case (sel)
			KW_NULL:  w = "null";
			KW_FALSE: w = "false";
			default:  w = "true";
		endcase
		c = 8'h00;
		if (pos < w.len()) begin
			c = w[pos];
			if (caps)
				c = c - 8'h20;
		end
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic void add_token(input logic [KIND_W-1:0] kind,
			input logic [ERR_W-1:0] err, input logic [LEN_W-1:0] len);
		jts_result_t t;
		t.kind = kind;
		t.err  = err;
		t.line = cur_line;
		t.len  = len;
		t.last = 1'b0;
		tokens_due.push_back(t);
	endfunction

	function automatic void bump_line();
		if (cur_line != '1)
			cur_line = cur_line + 1'b1;
	endfunction

	function automatic void grow_text();
		if (text_len < LEXEME_MAX)
			text_len = text_len + 1'b1;
	endfunction

	function automatic void after_error(input logic [7:0] b);
		if (b == CH_LF) begin
			bump_line();
			mode = SCAN_IDLE;
		end else begin
			mode = SCAN_SKIP;
		end
	endfunction

	// a byte seen with no token open
	function automatic void scan_fresh(input logic [7:0] b);
		mode = SCAN_IDLE;
		if (b == CH_LF) begin
			bump_line();
			return;
		end
		if (b == " " || b == CH_TAB)
			return;
		case (b)
			"[": begin add_token(TK_LBRACKET, EC_NONE, LEN_W'(1)); return; end
			"]": begin add_token(TK_RBRACKET, EC_NONE, LEN_W'(1)); return; end
			"{": begin add_token(TK_LBRACE, EC_NONE, LEN_W'(1)); return; end
			"}": begin add_token(TK_RBRACE, EC_NONE, LEN_W'(1)); return; end
			",": begin add_token(TK_COMMA, EC_NONE, LEN_W'(1)); return; end
			":": begin add_token(TK_COLON, EC_NONE, LEN_W'(1)); return; end
			default: ;
		endcase
		text_len = LEN_W'(1);
		if (b == "\"") begin
			mode = SCAN_STRING;
			return;
		end
		if (is_digit(b) || b == "+" || b == "-") begin
			mode = SCAN_NUMBER;
			num_ph = NP_INT;
			return;
		end
		if (b == "n" || b == "N" || b == "f" || b == "F" || b == "t" || b == "T") begin
			kw_which = (b == "n" || b == "N") ? KW_NULL :
				(b == "f" || b == "F") ? KW_FALSE : KW_TRUE;
			kw_caps = (b < "a");
			kw_at = 3'd1;
			mode = SCAN_WORD;
			return;
		end
		text_len = '0;
		add_token(TK_ERROR, EC_UNEXPECTED, '0);
		mode = SCAN_SKIP;
	endfunction

	function automatic void scan_item(input logic [7:0] b, input logic eoi);
		int          base;
		jts_result_t t;
		logic [2:0]  nxt;
		logic [2:0]  code;
		logic [7:0]  want;
		logic        dig;
		logic        ee;
		base = tokens_due.size();
		dig = is_digit(b);
		ee = (b == "e" || b == "E");
		if (eoi) begin
			case (mode)
				SCAN_STRING: add_token(TK_STRING, EC_UNTERM, text_len);
				SCAN_NUMBER: begin
					if (num_ph == NP_POINT || num_ph == NP_EXP || num_ph == NP_EXPSIGN)
						add_token(TK_ERROR, EC_EOF_NUM, '0);
					else
						add_token(TK_NUMBER, EC_NONE, text_len);
				end
				SCAN_WORD: add_token(TK_ERROR, EC_UNEXPECTED, '0);
				default: ;
			endcase
			add_token(TK_EOF, EC_NONE, '0);
			mode = SCAN_IDLE;
			num_ph = NP_INT;
			kw_at = '0;
			text_len = '0;
		end else begin
			case (mode)
				SCAN_STRING: begin
					if (b == "\"") begin
						grow_text();
						add_token(TK_STRING, EC_NONE, text_len);
						mode = SCAN_IDLE;
					end else if (b == "," || b == ":" || b == CH_LF) begin
						add_token(TK_STRING, EC_UNTERM, text_len);
						if (b == CH_LF)
							bump_line();
						mode = SCAN_IDLE;
					end else begin
						grow_text();
					end
				end
				SCAN_NUMBER: begin
					code = EC_NONE;
					case (num_ph)
						NP_INT:   nxt = dig ? NP_INT : (b == ".") ? NP_POINT :
							ee ? NP_EXP : NP_DONE;
						NP_POINT: begin
							nxt = dig ? NP_FRAC : NP_BAD;
							code = EC_POINT;
						end
						NP_FRAC:  nxt = dig ? NP_FRAC : ee ? NP_EXP : NP_DONE;
						NP_EXP: begin
							nxt = (b == "+" || b == "-") ? NP_EXPSIGN :
								dig ? NP_EXPDIG : NP_BAD;
							code = EC_EXP;
						end
						NP_EXPSIGN: begin
							nxt = dig ? NP_EXPDIG : NP_BAD;
							code = EC_SIGN;
						end
						default:  nxt = dig ? NP_EXPDIG : NP_DONE;
					endcase
					if (nxt <= NP_EXPDIG) begin
						grow_text();
						num_ph = nxt;
					end else if (nxt == NP_BAD) begin
						add_token(TK_ERROR, code, '0);
						num_ph = NP_INT;
						after_error(b);
					end else begin
						// the closing byte starts the next token
						add_token(TK_NUMBER, EC_NONE, text_len);
						num_ph = NP_INT;
						scan_fresh(b);
					end
				end
				SCAN_WORD: begin
					want = word_letter(kw_which, kw_at, kw_caps);
					if (want != 8'h00 && b == want) begin
						grow_text();
						kw_at = kw_at + 1'b1;
						if (kw_at >= word_size(kw_which)) begin
							add_token(word_kind(kw_which), EC_NONE, text_len);
							kw_at = '0;
							mode = SCAN_IDLE;
						end
					end else begin
						add_token(TK_ERROR, EC_UNEXPECTED, '0);
						kw_at = '0;
						after_error(b);
					end
				end
				SCAN_SKIP: begin
					if (b == CH_LF) begin
						bump_line();
						mode = SCAN_IDLE;
					end
				end
				default: scan_fresh(b);
			endcase
		end
		if (tokens_due.size() > base) begin
			t = tokens_due.pop_back();
			t.last = 1'b1;
			tokens_due.push_back(t);
		end
	endfunction

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_ch.valid <= 1'b0;
			bytes_ch.byte_in <= 8'h00;
			bytes_ch.end_of_input <= 1'b0;
		end else begin
			if (bytes_ch.valid && bytes_ch.ready) begin
				scan_item(bytes_ch.byte_in, bytes_ch.end_of_input);
				byte_backlog.delete(0);
			end
			if (!bytes_ch.valid || bytes_ch.ready) begin
				if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					bytes_ch.valid <= 1'b1;
					bytes_ch.byte_in <= byte_backlog[0].b;
					bytes_ch.end_of_input <= byte_backlog[0].eoi;
				end else begin
					bytes_ch.valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// sink side
	always @(posedge clk or negedge arst_n) begin : token_monitor
		jts_result_t want;
		if (!arst_n) begin
			tokens_ch.ready <= 1'b0;
			hold_left = 0;
			hold_seen = 1'b0;
		end else begin
			if (tokens_ch.valid && tokens_ch.ready) begin
				if (tokens_due.size() == 0) begin
					$error("token with nothing pending: kind %0d, line %0d",
						tokens_ch.token_kind, tokens_ch.line_number);
					mismatches++;
				end else begin
					want = tokens_due.pop_front();
					check_field("token_kind", want.kind, tokens_ch.token_kind);
					check_field("error_code", want.err, tokens_ch.error_code);
					check_field("line_number", want.line, tokens_ch.line_number);
					check_field("lexeme_length", want.len, tokens_ch.lexeme_length);
					check_field("last_result", want.last, tokens_ch.last_result);
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				tokens_ch.ready <= 1'b0;
			end else begin
				tokens_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	// counts cycles with work outstanding and no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((bytes_ch.valid && bytes_ch.ready) || (tokens_ch.valid && tokens_ch.ready))
				quiet_cycles = 0;
			else if (byte_backlog.size() != 0 || tokens_due.size() != 0)
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic void queue_byte(input logic [7:0] b);
		src_byte_t s;
		s.b = b;
		s.eoi = 1'b0;
		byte_backlog.push_back(s);
	endfunction

	function automatic void queue_eof();
		src_byte_t s;
		s.b = 8'($urandom_range(0, 255));
		s.eoi = 1'b1;
		byte_backlog.push_back(s);
	endfunction

	function automatic void queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (is_digit(b))
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic void maybe_newline();
		if ($urandom_range(0, 9) < 6)
			queue_byte(CH_LF);
	endfunction

	// the byte that breaks a number, or end of input right there
	function automatic void break_number();
		if ($urandom_range(0, 4) == 0) begin
			queue_eof();
		end else begin
			queue_byte(non_digit());
			maybe_newline();
		end
	endfunction

	function automatic void queue_string();
		int         n;
		logic [7:0] c;
		queue_byte("\"");
		n = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
		repeat (n) begin
			c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(32, 126));
			while (c == "\"" || c == "," || c == ":" || c == CH_LF)
				c = 8'($urandom_range(0, 255));
			queue_byte(c);
		end
		case ($urandom_range(0, 9))
			6:       queue_byte(",");
			7:       queue_byte(":");
			8:       queue_byte(CH_LF);
			9:       queue_eof();
			default: queue_byte("\"");
		endcase
	endfunction

	function automatic void queue_number();
		int sign_pick;
		int n;
		sign_pick = $urandom_range(0, 3);
		if (sign_pick == 0)
			queue_byte("-");
		else if (sign_pick == 1)
			queue_byte("+");
		n = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 4);
		// a sign on its own is a whole number
		if (sign_pick < 2 && $urandom_range(0, 7) == 0)
			n = 0;
		repeat (n) queue_byte(8'h30 + 8'($urandom_range(0, 9)));
		if (n > 0) begin
			case ($urandom_range(0, 5))
				0, 1: begin
					queue_byte(".");
					repeat ($urandom_range(1, 3)) queue_byte(8'h30 + 8'($urandom_range(0, 9)));
				end
				2: begin
					queue_byte(".");
					break_number();
					return;
				end
				default: ;
			endcase
			case ($urandom_range(0, 5))
				0, 1: begin
					queue_byte($urandom_range(0, 1) ? "e" : "E");
					if ($urandom_range(0, 1))
						queue_byte($urandom_range(0, 1) ? "+" : "-");
					repeat ($urandom_range(1, 3)) queue_byte(8'h30 + 8'($urandom_range(0, 9)));
				end
				2: begin
					queue_byte($urandom_range(0, 1) ? "e" : "E");
					break_number();
					return;
				end
				3: begin
					queue_byte($urandom_range(0, 1) ? "e" : "E");
					queue_byte($urandom_range(0, 1) ? "+" : "-");
					break_number();
					return;
				end
				default: ;
			endcase
		end
		case ($urandom_range(0, 7))
			0:       queue_byte(",");
			1:       queue_byte("]");
			2:       queue_byte("}");
			3:       queue_byte(" ");
			4:       queue_byte(CH_LF);
			5:       queue_eof();
			default: ;
		endcase
	endfunction

	function automatic void queue_keyword();
		logic [1:0] sel;
		logic       caps;
		int         cut;
		sel = 2'($urandom_range(0, 2));
		caps = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 4) != 0) begin
			for (int i = 0; i < word_size(sel); i++)
				queue_byte(word_letter(sel, 3'(i), caps));
		end else begin
			cut = $urandom_range(1, word_size(sel) - 1);
			for (int i = 0; i < cut; i++)
				queue_byte(word_letter(sel, 3'(i), caps));
			case ($urandom_range(0, 3))
				0: queue_eof();
				1: begin
					// right letter, wrong case
					queue_byte(word_letter(sel, 3'(cut), !caps));
					maybe_newline();
				end
				default: begin
					queue_byte(8'($urandom_range(0, 255)));
					maybe_newline();
				end
			endcase
		end
	endfunction

	function automatic void queue_fragment();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			case ($urandom_range(0, 5))
				0:       queue_byte("[");
				1:       queue_byte("]");
				2:       queue_byte("{");
				3:       queue_byte("}");
				4:       queue_byte(",");
				default: queue_byte(":");
			endcase
		end else if (pick < 24) begin
			case ($urandom_range(0, 2))
				0:       queue_byte(" ");
				1:       queue_byte(CH_TAB);
				default: queue_byte(CH_LF);
			endcase
		end else if (pick < 42) begin
			queue_string();
		end else if (pick < 64) begin
			queue_number();
		end else if (pick < 82) begin
			queue_keyword();
		end else if (pick < 97) begin
			queue_byte(8'($urandom_range(0, 255)));
			maybe_newline();
		end else begin
			queue_eof();
		end
	endfunction

	task automatic queue_random(input int n);
		int target;
		target = byte_backlog.size() + n;
		while (byte_backlog.size() < target)
			queue_fragment();
	endtask

	task automatic wait_drained();
		while (byte_backlog.size() != 0 || bytes_ch.valid || tokens_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		mismatches = 0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		mode = SCAN_IDLE;
		num_ph = NP_INT;
		kw_which = KW_NULL;
		kw_at = '0;
		kw_caps = 1'b0;
		text_len = '0;
		cur_line = LINE_W'(1);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		queue_text("[]{},:\"a\"-1.2E+3 TRUE\tfalse null\n");
		queue_eof();
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
				default: begin src_idle_pct = 14; sink_stall_pct = 14; end
			endcase
			queue_random(85);
			// source holds back until every token is out
			wait_drained();
			queue_random(85);
			wait_drained();
			if (ph == 0) begin
				// long sink hold while bytes keep coming, so the input backs up
				hold_req = !hold_req;
				@(posedge clk);
				queue_text("[[{{,,::]]}}[{,:]}[[{{,,");
				wait_drained();
			end
		end

		src_idle_pct = 0;
		sink_stall_pct = 0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
